// ===== rtl/lfta_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfta_pkg: shared types and constants of the lane follow / turn / avoid unit
// event codes, mode codes, request and result payloads, fixed-point constants
// ----------------------------------------------------------------------------
package lfta_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // event kinds of one request
  typedef enum logic [2:0] {
    ACT_TICK  = 3'd0,
    ACT_YAW   = 3'd1,
    ACT_LANE  = 3'd2,
    ACT_FRONT = 3'd3,
    ACT_CMD   = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    CMD_STOP   = 3'd0,
    CMD_GO     = 3'd1,
    CMD_PARK   = 3'd2,
    CMD_AROUND = 3'd3,
    CMD_LEFT   = 3'd4,
    CMD_RIGHT  = 3'd5
  } command_e;

  typedef enum logic [1:0] {
    MODE_STOP   = 2'd0,
    MODE_NORMAL = 2'd1,
    MODE_AVOID  = 2'd2,
    MODE_PARK   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    AVS_IDLE       = 3'd0,
    AVS_WAIT       = 3'd1,
    AVS_TURN_RIGHT = 3'd2,
    AVS_SEARCH     = 3'd3,
    AVS_FORWARD    = 3'd4,
    AVS_TURN_LEFT  = 3'd5
  } avoid_step_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSET_GAIN     = 3'd0,
    CFG_ANGLE_GAIN      = 3'd1,
    CFG_CRUISE_SPEED    = 3'd2,
    CFG_TURN_RATE_LIMIT = 3'd3,
    CFG_HEADING_GAIN    = 3'd4,
    CFG_HEADING_TOL     = 3'd5,
    CFG_DANGER_LEVEL    = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0]         action;
    logic [15:0]        yaw_angle;
    logic               left_line_seen;
    logic               right_line_seen;
    logic signed [15:0] center_offset;
    logic signed [15:0] heading_error;
    logic [11:0]        front_distance;
    logic [2:0]         command_code;
  } req_t;

  typedef struct packed {
    logic [14:0]        linear_velocity;
    logic signed [15:0] angular_velocity;
    logic [1:0]         drive_mode;
    logic               turn_active;
  } res_t;

  // fixed-point constants
  localparam logic [15:0] QUARTER_TURN = 16'h4000;
  localparam logic [14:0] PI_Q13       = 15'd25736;
  localparam logic [16:0] UNIT_Q12     = 17'd4096;
  localparam logic [12:0] SCALE_FLOOR  = 13'd819;
  localparam logic [14:0] CREEP_SPEED  = 15'd205;

  // register reset values
  localparam logic [15:0] OFFSET_GAIN_RST  = 16'd4096;
  localparam logic [15:0] ANGLE_GAIN_RST   = 16'd3277;
  localparam logic [14:0] CRUISE_SPEED_RST = 15'd614;
  localparam logic [14:0] RATE_LIMIT_RST   = 15'd4915;
  localparam logic [15:0] HEADING_GAIN_RST = 16'd6144;
  localparam logic [13:0] HEADING_TOL_RST  = 14'd364;
  localparam logic [11:0] DANGER_LEVEL_RST = 12'd600;
  localparam logic [30:0] HEADING_K_RST    = 31'(32'd6144 * 32'd25736);

  // clamp a rounded magnitude to the rate limit, then apply the sign
  function automatic logic signed [15:0] sat_rate(input logic [23:0] mag,
                                                   input logic        neg,
                                                   input logic [14:0] lim);
    logic [14:0] m;
    m = (mag > {9'd0, lim}) ? lim : mag[14:0];
    return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

endpackage

// ===== rtl/lfta_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfta_stream_if: valid / ready channel
// carries one payload per request, moved when valid and ready are both high
// ----------------------------------------------------------------------------
interface lfta_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/lane_follow_turn_avoid_controller_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lane_follow_turn_avoid_controller_unit: drive controller
// lane following, quarter turns on heading and a stepped obstacle bypass
// ----------------------------------------------------------------------------
// Each request is one event: a control tick, a yaw update, a lane report, a
// front distance sample or a drive command. Only a tick produces a result
// (linear velocity, angular velocity, mode, turn pending). The unit takes one
// request per clock cycle while no tick waits for the result register; a
// request is registered in the input register at acceptance and processed
// from there, and a tick result is registered in the result register that
// drives res_o. Each processed request updates the state (mode, bypass step,
// turn target, latest sensor values). The result register sits between the two
// channels, so requests keep flowing while a result waits; only a second tick holds
// until the waiting result is taken. Configuration registers by index:
// 0 offset gain, 1 angle gain, 2 cruise speed, 3 turn rate limit, 4 heading
// gain, 5 heading tolerance, 6 danger level; other indices are ignored.
// ----------------------------------------------------------------------------
module lane_follow_turn_avoid_controller_unit
  import lfta_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  lfta_stream_if.sink           req_i,
  lfta_stream_if.source         res_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // --------------------------------------------------------------------------
  // configuration registers
  // heading gain is kept premultiplied by pi so a tick needs one multiply
  // --------------------------------------------------------------------------
  logic [15:0] offset_gain_q, angle_gain_q;
  logic [14:0] cruise_q, rate_lim_q;
  logic [30:0] heading_k_q;
  logic [13:0] heading_tol_q;
  logic [11:0] danger_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_gain_q <= OFFSET_GAIN_RST;
      angle_gain_q  <= ANGLE_GAIN_RST;
      cruise_q      <= CRUISE_SPEED_RST;
      rate_lim_q    <= RATE_LIMIT_RST;
      heading_k_q   <= HEADING_K_RST;
      heading_tol_q <= HEADING_TOL_RST;
      danger_q      <= DANGER_LEVEL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_OFFSET_GAIN:     offset_gain_q <= cfg_data_i;
        CFG_ANGLE_GAIN:      angle_gain_q  <= cfg_data_i;
        CFG_CRUISE_SPEED:    cruise_q      <= cfg_data_i[14:0];
        CFG_TURN_RATE_LIMIT: rate_lim_q    <= cfg_data_i[14:0];
        CFG_HEADING_GAIN:    heading_k_q   <= 31'(cfg_data_i * PI_Q13);
        CFG_HEADING_TOL:     heading_tol_q <= cfg_data_i[13:0];
        CFG_DANGER_LEVEL:    danger_q      <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // input register and handshake
  // --------------------------------------------------------------------------
  logic in_vld_q;
  req_t in_q;
  logic is_tick, res_free, fire;

  assign is_tick  = (action_e'(in_q.action) == ACT_TICK);
  assign res_free = !res_o.valid || res_o.ready;
  // a tick needs the result register free, any other event goes straight through
  assign fire        = in_vld_q && (!is_tick || res_free);
  assign req_i.ready = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (req_i.ready) begin
      in_vld_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_q <= req_i.payload;
    end
  end

  // --------------------------------------------------------------------------
  // controller state
  // --------------------------------------------------------------------------
  mode_e              mode_q, mode_d;
  avoid_step_e        step_q, step_d;
  logic               turning_q, turning_d;
  logic [15:0]        target_q, target_d;
  logic [15:0]        heading_q, heading_d;
  logic               lane_vld_q, lane_vld_d;
  logic               lane_left_q, lane_left_d;
  logic               lane_right_q, lane_right_d;
  logic signed [15:0] lane_off_q, lane_off_d;
  logic signed [15:0] lane_ang_q, lane_ang_d;
  logic [11:0]        front_q, front_d;

  // --------------------------------------------------------------------------
  // turn law: wrapped yaw error times gain*pi, round away from zero, clamp
  // --------------------------------------------------------------------------
  logic signed [15:0] yaw_err;
  logic signed [16:0] yaw_err_x;
  logic [16:0]        yaw_err_mag;
  logic               turn_done;
  logic signed [47:0] turn_prod;
  logic [47:0]        turn_mag, turn_sum;
  logic signed [15:0] turn_rate;

  assign yaw_err     = $signed(target_q - heading_q);
  assign yaw_err_x   = {yaw_err[15], yaw_err};
  assign yaw_err_mag = yaw_err[15] ? 17'(-yaw_err_x) : 17'(yaw_err_x);
  assign turn_done   = yaw_err_mag < {3'd0, heading_tol_q};
  assign turn_prod   = $signed({1'b0, heading_k_q}) * yaw_err;
  assign turn_mag    = turn_prod[47] ? 48'(-turn_prod) : 48'(turn_prod);
  assign turn_sum    = turn_mag + (48'd1 << 27);
  assign turn_rate   = sat_rate({4'd0, turn_sum[47:28]}, turn_prod[47], rate_lim_q);

  // --------------------------------------------------------------------------
  // lane law: weighted offset and angle, speed scaled down by the offset
  // --------------------------------------------------------------------------
  logic signed [32:0] off_prod, ang_prod;
  logic signed [33:0] lane_sum;
  logic [33:0]        lane_mag, lane_rsum;
  logic signed [15:0] lane_rate;
  logic [16:0]        off_mag;
  logic [12:0]        spd_factor;
  logic [28:0]        lane_speed;

  assign off_prod  = $signed({1'b0, offset_gain_q}) * lane_off_q;
  assign ang_prod  = $signed({1'b0, angle_gain_q}) * lane_ang_q;
  assign lane_sum  = off_prod + ang_prod;
  assign lane_mag  = lane_sum[33] ? 34'(-lane_sum) : 34'(lane_sum);
  assign lane_rsum = lane_mag + 34'd2048;
  assign lane_rate = sat_rate({2'd0, lane_rsum[33:12]}, lane_sum[33], rate_lim_q);

  assign off_mag = lane_off_q[15] ? 17'(-{lane_off_q[15], lane_off_q})
                                  : {1'b0, lane_off_q};
  // floor of the scale is reached once the offset passes unit minus floor
  assign spd_factor = (off_mag >= (UNIT_Q12 - {4'd0, SCALE_FLOOR})) ? SCALE_FLOOR
                                                                     : 13'(UNIT_Q12 - off_mag);
  assign lane_speed = 29'(cruise_q * spd_factor) + 29'd2048;

  // --------------------------------------------------------------------------
  // event processing
  // --------------------------------------------------------------------------
  logic               line_seen;
  logic [14:0]        lin_v;
  logic signed [15:0] ang_v;
  avoid_step_e        step_v;
  logic               res_vld_q, res_vld_d;
  res_t               res_q, res_d;

  assign line_seen = lane_left_q || lane_right_q;

  always_comb begin
    mode_d       = mode_q;
    step_d       = step_q;
    turning_d    = turning_q;
    target_d     = target_q;
    heading_d    = heading_q;
    lane_vld_d   = lane_vld_q;
    lane_left_d  = lane_left_q;
    lane_right_d = lane_right_q;
    lane_off_d   = lane_off_q;
    lane_ang_d   = lane_ang_q;
    front_d      = front_q;
    lin_v        = '0;
    ang_v        = '0;
    step_v       = step_q;
    res_d        = res_q;
    res_vld_d    = res_vld_q && !res_o.ready;

    if (fire) begin
      case (action_e'(in_q.action))
        ACT_TICK: begin
          if (turning_q) begin
            // pending turn wins over the mode
            if (turn_done) turning_d = 1'b0;
            else           ang_v     = turn_rate;
          end else begin
            case (mode_q)
              MODE_NORMAL: begin
                if (lane_vld_q && line_seen) begin
                  ang_v = lane_rate;
                  lin_v = lane_speed[26:12];
                end
              end
              MODE_AVOID: begin
                if (step_q == AVS_WAIT && front_q > danger_q) begin
                  // blocked ahead: swing right a quarter turn
                  turning_d = 1'b1;
                  target_d  = heading_q - QUARTER_TURN;
                  step_d    = AVS_TURN_RIGHT;
                end else begin
                  if (step_v == AVS_TURN_RIGHT) step_v = AVS_SEARCH;
                  if (step_v == AVS_SEARCH) begin
                    if (!line_seen) lin_v  = CREEP_SPEED;
                    else            step_v = AVS_FORWARD;
                  end
                  if (step_v == AVS_FORWARD) begin
                    if (line_seen) begin
                      lin_v = cruise_q;
                    end else begin
                      // lane lost: swing back left
                      turning_d = 1'b1;
                      target_d  = heading_q + QUARTER_TURN;
                      step_v    = AVS_TURN_LEFT;
                    end
                  end
                  step_d = step_v;
                end
              end
              default: ;
            endcase
          end
          res_vld_d             = 1'b1;
          res_d.linear_velocity  = lin_v;
          res_d.angular_velocity = ang_v;
          res_d.drive_mode       = mode_q;
          res_d.turn_active      = turning_d;
        end
        ACT_YAW: heading_d = in_q.yaw_angle;
        ACT_LANE: begin
          lane_vld_d   = 1'b1;
          lane_left_d  = in_q.left_line_seen;
          lane_right_d = in_q.right_line_seen;
          lane_off_d   = in_q.center_offset;
          lane_ang_d   = in_q.heading_error;
        end
        ACT_FRONT: front_d = in_q.front_distance;
        ACT_CMD: begin
          case (command_e'(in_q.command_code))
            CMD_STOP: mode_d = MODE_STOP;
            CMD_GO:   mode_d = MODE_NORMAL;
            CMD_PARK: mode_d = MODE_PARK;
            CMD_AROUND: begin
              mode_d = MODE_AVOID;
              step_d = AVS_WAIT;
            end
            CMD_LEFT: begin
              turning_d = 1'b1;
              target_d  = heading_q + QUARTER_TURN;
            end
            CMD_RIGHT: begin
              turning_d = 1'b1;
              target_d  = heading_q - QUARTER_TURN;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_STOP;
      step_q       <= AVS_IDLE;
      turning_q    <= 1'b0;
      target_q     <= '0;
      heading_q    <= '0;
      lane_vld_q   <= 1'b0;
      lane_left_q  <= 1'b0;
      lane_right_q <= 1'b0;
      lane_off_q   <= '0;
      lane_ang_q   <= '0;
      front_q      <= '0;
      res_vld_q    <= 1'b0;
    end else begin
      mode_q       <= mode_d;
      step_q       <= step_d;
      turning_q    <= turning_d;
      target_q     <= target_d;
      heading_q    <= heading_d;
      lane_vld_q   <= lane_vld_d;
      lane_left_q  <= lane_left_d;
      lane_right_q <= lane_right_d;
      lane_off_q   <= lane_off_d;
      lane_ang_q   <= lane_ang_d;
      front_q      <= front_d;
      res_vld_q    <= res_vld_d;
    end
  end

  // result payload holds while waiting, only a processed tick reloads it
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o.valid   = res_vld_q;
  assign res_o.payload = res_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // a taken result is not followed by another unless a tick was processed
  a_no_result_without_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.ready && !(fire && is_tick) |=> !res_o.valid)
    else $error("result appeared without a tick");

  // stop and parking drive nothing once no turn is pending
  a_idle_modes_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.payload.turn_active &&
    (res_o.payload.drive_mode == MODE_STOP || res_o.payload.drive_mode == MODE_PARK)
    |-> res_o.payload.linear_velocity == '0 && res_o.payload.angular_velocity == '0)
    else $error("nonzero velocity in stop or parking");

  // forward motion never coincides with a pending turn
  a_no_drive_while_turning: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.payload.linear_velocity != '0 |-> !res_o.payload.turn_active)
    else $error("forward speed while a turn is pending");

  // a held request is neither dropped nor overwritten
  a_input_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !fire |=> in_vld_q && $stable(in_q))
    else $error("stalled request lost");

endmodule

// ===== test/lane_follow_turn_avoid_controller_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lane_follow_turn_avoid_controller_unit_tb: self-checking bench of the drive
// controller
// a short directed table covers field extremes, every event and command, lane
// loss, the half-circle heading error and one full obstacle bypass; random
// episodes of lane following, bypasses and heading turns follow under several
// register settings, each tick result checked against a behavioral model
// ----------------------------------------------------------------------------
module lane_follow_turn_avoid_controller_unit_tb;
  import lfta_pkg::*;

  localparam int  RAND_ITEMS  = 1650;
  localparam int  PHASES      = 6;
  localparam int  PH_MAX      = 1;
  localparam int  PH_ZERO     = 2;
  localparam int  PH_RESET    = 3;
  localparam int  PH_CALM     = 4;
  localparam int  DRAIN_LIMIT = 20000;
  localparam int  MAX_REPORTS = 10;
  localparam int  TURN_SHIFT  = 28;
  localparam int  Q12_SHIFT   = 12;
  localparam longint HALF_Q12 = 2048;

  // codes the block must ignore
  localparam logic [2:0]           ACT_SPARE = 3'd7;
  localparam logic [2:0]           CMD_SPARE = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  logic clk_i;
  logic rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  lfta_stream_if #(.payload_t(req_t)) req_if ();
  lfta_stream_if #(.payload_t(res_t)) res_if ();

  lane_follow_turn_avoid_controller_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .res_o      (res_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // --------------------------------------------------------------------------
  // behavioral copy of the controller: registers and state
  // --------------------------------------------------------------------------
  logic [15:0]        k_offset, k_angle, k_heading;
  logic [14:0]        v_cruise, w_limit;
  logic [13:0]        tol_bam;
  logic [11:0]        danger_thr;

  mode_e              cur_mode;
  avoid_step_e        bypass_step;
  logic               turn_pending;
  logic [15:0]        aim_yaw, yaw_now;
  logic               lane_seen, left_seen, right_seen;
  logic signed [15:0] lane_off, lane_ang;
  logic [11:0]        front_now;

  res_t cmd_expect_q[$];   // velocity commands still to come out, oldest first
  int   errors;
  int   events_sent;       // requests that do something, ignored codes excluded
  bit   calm;              // no idling on either side while set

  // signed divide by 2^sh, ties away from zero
  function automatic longint round_half_away(input longint v, input int sh);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (longint'(1) << (sh - 1))) >> sh;
    return (v < 0) ? -m : m;
  endfunction

  function automatic logic signed [15:0] clamp_rate(input longint w);
    longint lim;
    lim = longint'(w_limit);
    if (w > lim) w = lim;
    else if (w < -lim) w = -lim;
    return 16'(w);
  endfunction

  function automatic void begin_turn(input bit left);
    turn_pending = 1'b1;
    aim_yaw = left ? yaw_now + QUARTER_TURN : yaw_now - QUARTER_TURN;
  endfunction

  // velocity command produced by one control tick, state advanced in place
  function automatic res_t tick_command();
    res_t               o;
    logic signed [15:0] d;
    longint             e, mag, s, w;
    bit                 line;
    o = '0;
    line = left_seen || right_seen;
    if (turn_pending) begin
      // heading error wraps modulo a full circle
      d = aim_yaw - yaw_now;
      e = d;
      mag = (e < 0) ? -e : e;
      if (mag < longint'(tol_bam)) turn_pending = 1'b0;
      else o.angular_velocity = clamp_rate(round_half_away(
             longint'(k_heading) * e * longint'(PI_Q13), TURN_SHIFT));
    end else if (cur_mode == MODE_NORMAL) begin
      if (lane_seen && line) begin
        w = longint'(k_offset) * longint'(lane_off) + longint'(k_angle) * longint'(lane_ang);
        o.angular_velocity = clamp_rate(round_half_away(w, Q12_SHIFT));
        mag = (lane_off < 0) ? -longint'(lane_off) : longint'(lane_off);
        s = longint'(UNIT_Q12) - mag;
        if (s < longint'(SCALE_FLOOR)) s = longint'(SCALE_FLOOR);
        o.linear_velocity = 15'((longint'(v_cruise) * s + HALF_Q12) >> Q12_SHIFT);
      end
    end else if (cur_mode == MODE_AVOID) begin
      if (bypass_step == AVS_WAIT && front_now > danger_thr) begin
        begin_turn(1'b0);
        bypass_step = AVS_TURN_RIGHT;
      end else begin
        if (bypass_step == AVS_TURN_RIGHT) bypass_step = AVS_SEARCH;
        // creep until a lane line shows, then cruise along it until it is lost
        if (bypass_step == AVS_SEARCH) begin
          if (!line) o.linear_velocity = CREEP_SPEED;
          else bypass_step = AVS_FORWARD;
        end
        if (bypass_step == AVS_FORWARD) begin
          if (line) o.linear_velocity = v_cruise;
          else begin
            begin_turn(1'b1);
            bypass_step = AVS_TURN_LEFT;
          end
        end
      end
    end
    o.drive_mode = cur_mode;
    o.turn_active = turn_pending;
    return o;
  endfunction

  // fold one accepted request into the state, return 1 when it yields a result
  function automatic bit step_controller(input req_t r, output res_t o);
    o = '0;
    case (r.action)
      ACT_TICK: begin
        o = tick_command();
        return 1'b1;
      end
      ACT_YAW: yaw_now = r.yaw_angle;
      ACT_LANE: begin
        lane_seen = 1'b1;
        left_seen = r.left_line_seen;
        right_seen = r.right_line_seen;
        lane_off = r.center_offset;
        lane_ang = r.heading_error;
      end
      ACT_FRONT: front_now = r.front_distance;
      ACT_CMD: begin
        case (r.command_code)
          CMD_STOP:   cur_mode = MODE_STOP;
          CMD_GO:     cur_mode = MODE_NORMAL;
          CMD_PARK:   cur_mode = MODE_PARK;
          CMD_AROUND: begin
            cur_mode = MODE_AVOID;
            bypass_step = AVS_WAIT;
          end
          CMD_LEFT:   begin_turn(1'b1);
          CMD_RIGHT:  begin_turn(1'b0);
          default: ;
        endcase
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // --------------------------------------------------------------------------
  // request builders: unused fields carry random bits
  // --------------------------------------------------------------------------
  function automatic req_t junk_req();
    req_t r;
    r.action          = 3'($urandom_range(0, 7));
    r.yaw_angle       = 16'($urandom);
    r.left_line_seen  = 1'($urandom);
    r.right_line_seen = 1'($urandom);
    r.center_offset   = 16'($urandom);
    r.heading_error   = 16'($urandom);
    r.front_distance  = 12'($urandom);
    r.command_code    = 3'($urandom_range(0, 7));
    return r;
  endfunction

  function automatic req_t mk_tick();
    req_t r;
    r = junk_req();
    r.action = ACT_TICK;
    return r;
  endfunction

  function automatic req_t mk_yaw(input logic [15:0] y);
    req_t r;
    r = junk_req();
    r.action = ACT_YAW;
    r.yaw_angle = y;
    return r;
  endfunction

  function automatic req_t mk_lane(input bit l, input bit rt,
                                   input logic signed [15:0] off,
                                   input logic signed [15:0] ang);
    req_t r;
    r = junk_req();
    r.action = ACT_LANE;
    r.left_line_seen = l;
    r.right_line_seen = rt;
    r.center_offset = off;
    r.heading_error = ang;
    return r;
  endfunction

  function automatic req_t mk_front(input logic [11:0] f);
    req_t r;
    r = junk_req();
    r.action = ACT_FRONT;
    r.front_distance = f;
    return r;
  endfunction

  function automatic req_t mk_cmd(input logic [2:0] c);
    req_t r;
    r = junk_req();
    r.action = ACT_CMD;
    r.command_code = c;
    return r;
  endfunction

  // lane report mostly with a line and a modest offset, sometimes anything
  function automatic req_t rand_lane();
    req_t r;
    r = mk_lane(1'($urandom), 1'($urandom), 16'($urandom), 16'($urandom));
    if ($urandom_range(9) != 0 && !r.left_line_seen && !r.right_line_seen)
      r.left_line_seen = 1'b1;
    if ($urandom_range(7) != 0) r.center_offset = 16'($urandom_range(0, 8191) - 4096);
    if ($urandom_range(7) != 0) r.heading_error = 16'($urandom_range(0, 6143) - 3072);
    return r;
  endfunction

  // front reading that counts as blocked, or the top reading when none can
  function automatic logic [11:0] blocked_reading();
    if (danger_thr == '1) return '1;
    return 12'($urandom_range(int'(danger_thr) + 1, 4095));
  endfunction

  function automatic res_t mk_res(input int lin, input int ang, input mode_e m,
                                  input bit t);
    return '{linear_velocity: 15'(lin), angular_velocity: 16'(ang),
             drive_mode: m, turn_active: t};
  endfunction

  // --------------------------------------------------------------------------
  // drivers: inputs move at the falling edge, handshakes seen at the rising one
  // --------------------------------------------------------------------------
  task automatic note_fault(input string what, input res_t want, input res_t got);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("%0t: %s: expected lin=%0d ang=%0d mode=%0d turn=%0b, got lin=%0d ang=%0d mode=%0d turn=%0b",
               $realtime, what, want.linear_velocity, want.angular_velocity,
               want.drive_mode, want.turn_active, got.linear_velocity,
               got.angular_velocity, got.drive_mode, got.turn_active);
  endtask

  // offer one request until taken; a typed row overrides the model's answer
  task automatic issue(input req_t r, input bit typed, input res_t want);
    bit   taken;
    res_t pred;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      if (!calm && $urandom_range(99) < 26) req_if.valid <= 1'b0;
      else begin
        req_if.valid <= 1'b1;
        req_if.payload <= r;
      end
      @(posedge clk_i);
      taken = req_if.valid && req_if.ready;
    end
    if (step_controller(r, pred)) cmd_expect_q.push_back(typed ? want : pred);
    if (r.action <= ACT_CMD && !(r.action == ACT_CMD && r.command_code > CMD_RIGHT))
      events_sent++;
  endtask

  task automatic feed(input req_t r);
    issue(r, 1'b0, '0);
  endtask

  // quiet the request side and let every pending result come out
  task automatic settle();
    int guard;
    guard = 0;
    @(negedge clk_i) req_if.valid <= 1'b0;
    while (cmd_expect_q.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    while (cmd_expect_q.size() != 0) note_fault("result never came", cmd_expect_q.pop_front(), '0);
    // non-tick requests may still be in the pipe
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= v;
    case (idx)
      CFG_OFFSET_GAIN:     k_offset = v;
      CFG_ANGLE_GAIN:      k_angle = v;
      CFG_CRUISE_SPEED:    v_cruise = v[14:0];
      CFG_TURN_RATE_LIMIT: w_limit = v[14:0];
      CFG_HEADING_GAIN:    k_heading = v;
      CFG_HEADING_TOL:     tol_bam = v[13:0];
      CFG_DANGER_LEVEL:    danger_thr = v[11:0];
      default: ;
    endcase
  endtask

  task automatic load_setting(input int p);
    logic [CFG_DATA_W-1:0] v [7];
    case (p)
      PH_MAX:   foreach (v[i]) v[i] = '1;
      PH_ZERO:  foreach (v[i]) v[i] = '0;
      PH_RESET: v = '{OFFSET_GAIN_RST, ANGLE_GAIN_RST, 16'(CRUISE_SPEED_RST),
                      16'(RATE_LIMIT_RST), HEADING_GAIN_RST, 16'(HEADING_TOL_RST),
                      16'(DANGER_LEVEL_RST)};
      default:  v = '{16'($urandom_range(0, 12000)), 16'($urandom_range(0, 12000)),
                      16'($urandom_range(0, 4096)), 16'($urandom_range(100, 12000)),
                      16'($urandom_range(0, 16000)), 16'($urandom_range(16, 2000)),
                      16'($urandom_range(0, 4095))};
    endcase
    cfg_write(CFG_OFFSET_GAIN, v[0]);
    cfg_write(CFG_ANGLE_GAIN, v[1]);
    cfg_write(CFG_CRUISE_SPEED, v[2]);
    cfg_write(CFG_TURN_RATE_LIMIT, v[3]);
    cfg_write(CFG_HEADING_GAIN, v[4]);
    cfg_write(CFG_HEADING_TOL, v[5]);
    cfg_write(CFG_DANGER_LEVEL, v[6]);
    // an unmapped index must leave every register alone
    if (p == PH_MAX) cfg_write(CFG_SPARE, '0);
    @(negedge clk_i) cfg_we <= 1'b0;
  endtask

  // walk the heading toward the turn target, halving the gap, then land
  // somewhere around it within the tolerance band
  task automatic steer_home();
    logic signed [15:0] gap;
    int                 jit;
    repeat ($urandom_range(1, 4)) begin
      gap = aim_yaw - yaw_now;
      feed(mk_yaw(yaw_now + 16'(gap >>> 1)));
      feed(mk_tick());
    end
    jit = $urandom_range(0, 2 * int'(tol_bam)) - int'(tol_bam);
    feed(mk_yaw(aim_yaw + 16'(jit)));
    feed(mk_tick());
    feed(mk_tick());
  endtask

  // one random scenario of related requests
  task automatic run_episode();
    int kind;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2, 3: begin
        // lane following with fresh reports between ticks
        feed(mk_cmd(CMD_GO));
        repeat ($urandom_range(4, 12)) begin
          feed(rand_lane());
          feed(mk_tick());
          if ($urandom_range(3) == 0) feed(mk_yaw(16'($urandom)));
        end
      end
      4, 5: begin
        // full obstacle bypass: block, turn right, search, follow, turn back
        feed(mk_cmd(CMD_AROUND));
        repeat ($urandom_range(0, 2)) begin
          feed(mk_front(12'($urandom_range(0, 4095))));
          feed(mk_tick());
        end
        feed(mk_front(blocked_reading()));
        feed(mk_tick());
        steer_home();
        feed(mk_lane(1'b0, 1'b0, 16'($urandom), 16'($urandom)));
        repeat ($urandom_range(1, 3)) feed(mk_tick());
        feed(rand_lane());
        repeat ($urandom_range(1, 3)) feed(mk_tick());
        feed(mk_lane(1'b0, 1'b0, 16'($urandom), 16'($urandom)));
        feed(mk_tick());
        steer_home();
      end
      6, 7: begin
        feed(mk_cmd($urandom_range(1) ? CMD_LEFT : CMD_RIGHT));
        steer_home();
      end
      8: begin
        // noise, ignored codes included
        repeat ($urandom_range(3, 8)) feed(junk_req());
        feed(mk_tick());
      end
      default: begin
        feed(mk_cmd($urandom_range(1) ? CMD_STOP : CMD_PARK));
        repeat ($urandom_range(1, 3)) feed(mk_tick());
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // directed table
  // --------------------------------------------------------------------------
  typedef struct {
    req_t r;
    bit   typed;
    res_t want;
  } plan_row_t;

  plan_row_t plan[$];

  function automatic void plan_row(input req_t r);
    plan.push_back('{r: r, typed: 1'b0, want: '0});
  endfunction

  function automatic void plan_check(input req_t r, input int lin, input int ang,
                                     input mode_e m, input bit t);
    plan.push_back('{r: r, typed: 1'b1, want: mk_res(lin, ang, m, t)});
  endfunction

  function automatic void build_plan();
    // right after reset everything is at rest
    plan_check(mk_tick(), 0, 0, MODE_STOP, 1'b0);
    plan_row(mk_cmd(CMD_GO));
    // normal mode before any lane report
    plan_check(mk_tick(), 0, 0, MODE_NORMAL, 1'b0);
    // offset and angle at both extremes, clamped rate, floored speed scale
    plan_row(mk_lane(1'b1, 1'b1, 16'sh7FFF, 16'sh7FFF));
    plan_row(mk_tick());
    plan_row(mk_lane(1'b1, 1'b0, 16'sh8000, 16'sh8000));
    plan_row(mk_tick());
    // lane report with no line seen
    plan_row(mk_lane(1'b0, 1'b0, '0, '0));
    plan_check(mk_tick(), 0, 0, MODE_NORMAL, 1'b0);
    // left turn across the zero heading, gain saturates the rate
    plan_row(mk_yaw(16'hFFFF));
    plan_row(mk_cmd(CMD_LEFT));
    plan_check(mk_tick(), 0, int'(RATE_LIMIT_RST), MODE_NORMAL, 1'b1);
    // retarget right, then sit exactly half a circle off
    plan_row(mk_cmd(CMD_RIGHT));
    plan_row(mk_yaw(16'h3FFF));
    plan_check(mk_tick(), 0, -int'(RATE_LIMIT_RST), MODE_NORMAL, 1'b1);
    // turn completes on the target, parking holds zero
    plan_row(mk_cmd(CMD_PARK));
    plan_row(mk_yaw(16'hBFFF));
    plan_check(mk_tick(), 0, 0, MODE_PARK, 1'b0);
    // bypass: blocked at the top reading, quarter turn right
    plan_row(mk_cmd(CMD_AROUND));
    plan_row(mk_front(12'hFFF));
    plan_check(mk_tick(), 0, 0, MODE_AVOID, 1'b1);
    plan_row(mk_yaw(16'h7FFF));
    plan_check(mk_tick(), 0, 0, MODE_AVOID, 1'b0);
    // no line yet: creep; line found: cruise; line lost: turn back left
    plan_check(mk_tick(), int'(CREEP_SPEED), 0, MODE_AVOID, 1'b0);
    plan_row(mk_lane(1'b0, 1'b1, 16'sd100, -16'sd100));
    plan_check(mk_tick(), int'(CRUISE_SPEED_RST), 0, MODE_AVOID, 1'b0);
    plan_row(mk_lane(1'b0, 1'b0, '0, '0));
    plan_check(mk_tick(), 0, 0, MODE_AVOID, 1'b1);
    // unused event and command codes change nothing
    plan_row('{action: ACT_SPARE, yaw_angle: '0, left_line_seen: 1'b1,
               right_line_seen: 1'b1, center_offset: '0, heading_error: '0,
               front_distance: '0, command_code: CMD_STOP});
    plan_row(mk_cmd(CMD_SPARE));
    // a pending turn still drives the wheels in stop mode
    plan_row(mk_cmd(CMD_STOP));
    plan_check(mk_tick(), 0, int'(RATE_LIMIT_RST), MODE_STOP, 1'b1);
  endfunction

  // --------------------------------------------------------------------------
  // clock, result side and checking
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    res_if.ready <= calm || ($urandom_range(99) >= 26);
  end

  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got = res_if.payload;
      if (cmd_expect_q.size() == 0) note_fault("result with nothing pending", '0, got);
      else begin
        want = cmd_expect_q.pop_front();
        if (got.linear_velocity !== want.linear_velocity)
          note_fault("linear velocity mismatch", want, got);
        else if (got.angular_velocity !== want.angular_velocity)
          note_fault("angular velocity mismatch", want, got);
        else if (got.drive_mode !== want.drive_mode)
          note_fault("drive mode mismatch", want, got);
        else if (got.turn_active !== want.turn_active)
          note_fault("turn flag mismatch", want, got);
      end
    end
  end

  // hard stop in case a handshake hangs
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    int goal;
    errors = 0;
    events_sent = 0;
    calm = 1'b0;
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.payload = '0;
    res_if.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;

    // model registers and state as they leave reset
    k_offset = OFFSET_GAIN_RST;
    k_angle = ANGLE_GAIN_RST;
    v_cruise = CRUISE_SPEED_RST;
    w_limit = RATE_LIMIT_RST;
    k_heading = HEADING_GAIN_RST;
    tol_bam = HEADING_TOL_RST;
    danger_thr = DANGER_LEVEL_RST;
    cur_mode = MODE_STOP;
    bypass_step = AVS_IDLE;
    turn_pending = 1'b0;
    aim_yaw = '0;
    yaw_now = '0;
    lane_seen = 1'b0;
    left_seen = 1'b0;
    right_seen = 1'b0;
    lane_off = '0;
    lane_ang = '0;
    front_now = '0;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    build_plan();
    foreach (plan[i]) issue(plan[i].r, plan[i].typed, plan[i].want);

    // random episodes under one register setting per phase
    for (int p = 0; p < PHASES; p++) begin
      settle();
      load_setting(p);
      calm = (p == PH_CALM);
      goal = events_sent + RAND_ITEMS / PHASES;
      while (events_sent < goal) run_episode();
    end
    calm = 1'b0;
    settle();
    repeat (8) @(posedge clk_i);

    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
